### hw/rtl/sdb_pkg.sv
// shared constants, codes and types for the sector dirty bitmap
// depends on nothing; used by sdb_range, sector_dirty_bitmap and the testbench

package sdb_pkg;

   // map geometry
   localparam int SECTOR_COUNT   = 1048576;
   localparam int MARK_WORD_BITS = 64;
   localparam int MARK_WORDS     = SECTOR_COUNT / MARK_WORD_BITS;

   // widths
   localparam int SECTOR_IDX_W = $clog2(SECTOR_COUNT);
   localparam int SECTOR_CNT_W = SECTOR_IDX_W + 1;
   localparam int WORD_IDX_W   = $clog2(MARK_WORD_BITS);
   localparam int WORD_ADDR_W  = $clog2(MARK_WORDS);
   localparam int OFFSET_W     = 40;
   localparam int LENGTH_W     = 32;
   localparam int SHIFT_W      = 4;
   localparam int STATUS_W     = 2;
   localparam int RSTATE_W     = 2;

   // sector size limits
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd9;

   // command codes
   localparam logic CMD_SET  = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISALIGN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BEYOND   = 2'd2;

   // range state codes
   localparam logic [RSTATE_W-1:0] RSTATE_UNKNOWN = 2'd0;
   localparam logic [RSTATE_W-1:0] RSTATE_ALL_SET = 2'd1;
   localparam logic [RSTATE_W-1:0] RSTATE_ALL_CLR = 2'd2;
   localparam logic [RSTATE_W-1:0] RSTATE_BLENDED = 2'd3;

   // outcome of the range check for one transaction
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    run;
      logic [SECTOR_IDX_W-1:0] first;
      logic [SECTOR_CNT_W-1:0] count;
   } range_type;

endpackage

### hw/rtl/sdb_ram.sv
// generic single-port synchronous ram with registered read data
// depends on nothing

module sdb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read, read returns old data on a write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/sdb_range.sv
// range check: alignment, map bound and sector span of one transaction
// depends on sdb_pkg

module sdb_range (
   input  logic                            cmd,
   input  logic [sdb_pkg::OFFSET_W-1:0]    offset_bytes,
   input  logic [sdb_pkg::LENGTH_W-1:0]    length_bytes,
   input  logic [sdb_pkg::SHIFT_W-1:0]     shift,
   output sdb_pkg::range_type              range
);

   logic [sdb_pkg::OFFSET_W:0]   end_bytes;
   logic [sdb_pkg::OFFSET_W:0]   total_bytes;
   logic [sdb_pkg::OFFSET_W-1:0] low_mask;
   logic                         misaligned;
   logic                         beyond;
   logic [sdb_pkg::OFFSET_W-1:0] first_full;
   logic [sdb_pkg::LENGTH_W-1:0] count_set;
   logic [sdb_pkg::LENGTH_W:0]   len_round;
   logic [sdb_pkg::LENGTH_W:0]   count_test;

   // bound and alignment
   assign end_bytes   = {1'b0, offset_bytes}
                      + (sdb_pkg::OFFSET_W+1)'(length_bytes);
   assign total_bytes = (sdb_pkg::OFFSET_W+1)'(sdb_pkg::SECTOR_COUNT) << shift;
   assign low_mask    = ~({sdb_pkg::OFFSET_W{1'b1}} << shift);
   assign misaligned  = ((offset_bytes | sdb_pkg::OFFSET_W'(length_bytes)) & low_mask) != '0;
   assign beyond      = end_bytes > total_bytes;

   // sector span, test rounds the length up to whole sectors
   assign first_full = offset_bytes >> shift;
   assign count_set  = length_bytes >> shift;
   assign len_round  = {1'b0, length_bytes}
                     + ((sdb_pkg::LENGTH_W+1)'(1) << shift)
                     - (sdb_pkg::LENGTH_W+1)'(1);
   assign count_test = len_round >> shift;

   // outcome
   always_comb begin
      range.first = first_full[sdb_pkg::SECTOR_IDX_W-1:0];
      range.count = (cmd == sdb_pkg::CMD_SET) ? count_set[sdb_pkg::SECTOR_CNT_W-1:0]
                                              : count_test[sdb_pkg::SECTOR_CNT_W-1:0];
      range.status = sdb_pkg::STATUS_OK;
      range.run    = 1'b0;
      if ((cmd == sdb_pkg::CMD_SET) && misaligned) begin
         range.status = sdb_pkg::STATUS_MISALIGN;
      end else if (beyond) begin
         range.status = sdb_pkg::STATUS_BEYOND;
      end else begin
         range.run = (length_bytes != '0);
      end
   end

endmodule

### hw/rtl/sector_dirty_bitmap.sv
// sector dirty bitmap: one mark bit per sector in a 16384 x 64 ram
// sequence: check, launch, then a read and a modify step per mark word walked
// (through the single ram port); the result strobe is registered
// a new transaction is accepted only while idle; results cannot be stalled
// reset: synchronous; a clearing pass zeroes the ram, busy held high
// depends on sdb_pkg, sdb_ram, sdb_range

module sector_dirty_bitmap (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_command,
   input  logic [sdb_pkg::OFFSET_W-1:0]   req_offset_bytes,
   input  logic [sdb_pkg::LENGTH_W-1:0]   req_length_bytes,
   output logic                           rsp_valid,
   output logic [sdb_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sdb_pkg::RSTATE_W-1:0]   rsp_range_state,
   input  logic                           csr_wr_en,
   input  logic [sdb_pkg::SHIFT_W-1:0]    csr_wr_data
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_LAUNCH = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_MODIFY = 3'd5;

   localparam int WORD_TOP_W = sdb_pkg::SECTOR_CNT_W - sdb_pkg::WORD_IDX_W;

   logic [2:0]                           state_ff, state_in;
   logic [sdb_pkg::SHIFT_W-1:0]          shift_reg_ff;
   logic [sdb_pkg::SHIFT_W-1:0]          shift_eff;
   logic                                 cmd_ff;
   logic [sdb_pkg::OFFSET_W-1:0]         off_ff;
   logic [sdb_pkg::LENGTH_W-1:0]         len_ff;
   logic [sdb_pkg::SHIFT_W-1:0]          sh_ff;
   sdb_pkg::range_type                   range;
   sdb_pkg::range_type                   range_ff;
   logic [sdb_pkg::WORD_ADDR_W-1:0]      clr_ff, clr_in;
   logic [sdb_pkg::SECTOR_CNT_W-1:0]     sec_ff, sec_in;
   logic [sdb_pkg::SECTOR_CNT_W-1:0]     end_ff, end_in;
   logic                                 any_set_ff, any_set_in;
   logic                                 any_clr_ff, any_clr_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [sdb_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [sdb_pkg::RSTATE_W-1:0]         rsp_rstate_ff, rsp_rstate_in;
   logic                                 accept;

   logic                                 mem_we;
   logic [sdb_pkg::WORD_ADDR_W-1:0]      mem_addr;
   logic [sdb_pkg::MARK_WORD_BITS-1:0]   mem_wdata;
   logic [sdb_pkg::MARK_WORD_BITS-1:0]   mem_rdata;

   logic [sdb_pkg::SECTOR_CNT_W-1:0]     word_end;
   logic [sdb_pkg::SECTOR_CNT_W-1:0]     stop_sec;
   logic [sdb_pkg::SECTOR_CNT_W-1:0]     last_sec;
   logic [sdb_pkg::WORD_IDX_W-1:0]       lo_bit;
   logic [sdb_pkg::WORD_IDX_W-1:0]       hi_gap;
   logic [sdb_pkg::MARK_WORD_BITS-1:0]   span;
   logic [sdb_pkg::MARK_WORD_BITS-1:0]   hit;
   logic                                 word_set;
   logic                                 word_clr;
   logic                                 walk_done;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // sector size register, values above the limit act as the limit
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_reg_ff <= sdb_pkg::SHIFT_RESET;
      end else if (csr_wr_en) begin
         shift_reg_ff <= csr_wr_data;
      end
   end

   assign shift_eff = (shift_reg_ff > sdb_pkg::SHIFT_MAX) ? sdb_pkg::SHIFT_MAX : shift_reg_ff;

   // transaction capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         off_ff <= req_offset_bytes;
         len_ff <= req_length_bytes;
         sh_ff  <= shift_eff;
      end
   end

   sdb_range u_range (
      .cmd          (cmd_ff),
      .offset_bytes (off_ff),
      .length_bytes (len_ff),
      .shift        (sh_ff),
      .range        (range)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         range_ff <= range;
      end
   end

   // span of the current word: from the cursor to the word end or range end
   assign word_end = {sec_ff[sdb_pkg::SECTOR_CNT_W-1:sdb_pkg::WORD_IDX_W] + WORD_TOP_W'(1),
                      {sdb_pkg::WORD_IDX_W{1'b0}}};
   assign stop_sec = (end_ff < word_end) ? end_ff : word_end;
   assign last_sec = stop_sec - sdb_pkg::SECTOR_CNT_W'(1);
   assign lo_bit   = sec_ff[sdb_pkg::WORD_IDX_W-1:0];
   assign hi_gap   = sdb_pkg::WORD_IDX_W'(sdb_pkg::MARK_WORD_BITS - 1)
                   - last_sec[sdb_pkg::WORD_IDX_W-1:0];
   assign span     = ({sdb_pkg::MARK_WORD_BITS{1'b1}} << lo_bit)
                   & ({sdb_pkg::MARK_WORD_BITS{1'b1}} >> hi_gap);
   assign hit      = mem_rdata & span;
   assign word_set = (hit != '0);
   assign word_clr = (hit != span);

   // walk finishes at range end, or early for a test once both kinds are seen
   assign walk_done = (stop_sec == end_ff)
                   || ((cmd_ff == sdb_pkg::CMD_TEST) && (any_set_ff || word_set)
                       && (any_clr_ff || word_clr));

   // ram port: clearing pass, word read, read-modify-write of set marks
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = sec_ff[sdb_pkg::SECTOR_IDX_W-1:sdb_pkg::WORD_IDX_W];
      mem_wdata = mem_rdata | span;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_addr  = clr_ff;
         mem_wdata = '0;
      end else if ((state_ff == ST_MODIFY) && (cmd_ff == sdb_pkg::CMD_SET)) begin
         mem_we = 1'b1;
      end
   end

   sdb_ram #(
      .WIDTH (sdb_pkg::MARK_WORD_BITS),
      .DEPTH (sdb_pkg::MARK_WORDS)
   ) u_marks (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      sec_in        = sec_ff;
      end_in        = end_ff;
      any_set_in    = any_set_ff;
      any_clr_in    = any_clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_rstate_in = rsp_rstate_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + sdb_pkg::WORD_ADDR_W'(1);
            if (clr_ff == sdb_pkg::WORD_ADDR_W'(sdb_pkg::MARK_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            sec_in     = {1'b0, range_ff.first};
            end_in     = {1'b0, range_ff.first} + range_ff.count;
            any_set_in = 1'b0;
            any_clr_in = 1'b0;
            if (range_ff.run) begin
               state_in = ST_READ;
            end else begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = range_ff.status;
               rsp_rstate_in = sdb_pkg::RSTATE_UNKNOWN;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            any_set_in = any_set_ff || word_set;
            any_clr_in = any_clr_ff || word_clr;
            sec_in     = stop_sec;
            if (walk_done) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = sdb_pkg::STATUS_OK;
               if (cmd_ff == sdb_pkg::CMD_SET) begin
                  rsp_rstate_in = sdb_pkg::RSTATE_UNKNOWN;
               end else if (any_set_in && any_clr_in) begin
                  rsp_rstate_in = sdb_pkg::RSTATE_BLENDED;
               end else if (any_set_in) begin
                  rsp_rstate_in = sdb_pkg::RSTATE_ALL_SET;
               end else begin
                  rsp_rstate_in = sdb_pkg::RSTATE_ALL_CLR;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and result payload
   always_ff @(posedge clock) begin
      sec_ff        <= sec_in;
      end_ff        <= end_in;
      any_set_ff    <= any_set_in;
      any_clr_ff    <= any_clr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rstate_ff <= rsp_rstate_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_range_state = rsp_rstate_ff;

   // a result appears only once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a failed check never carries a range verdict
   a_fail_unknown: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != sdb_pkg::STATUS_OK))
         |-> (rsp_range_state == sdb_pkg::RSTATE_UNKNOWN))
      else $error("range state reported with failing status");

   // the marks change only during the clearing pass or a set walk
   a_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_CLEAR)
                  || ((state_ff == ST_MODIFY) && (cmd_ff == sdb_pkg::CMD_SET))))
      else $error("unexpected mark ram write");

endmodule

### tb/tb_top.sv
// self-checking testbench for sector_dirty_bitmap: directed and random set/test commands
// a scoreboard class predicts every reply from its own copy of the mark map and sector size
// depends on sdb_pkg and the sector_dirty_bitmap rtl

module tb_top;
   import sdb_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;

   // map size in bytes at the reset sector size
   localparam logic [OFFSET_W-1:0] MAP_BYTES_9 = 40'h00_2000_0000;

   // predicted mark map, sector size and the queue of replies still owed
   class mark_map_board;
      typedef struct packed {
         logic [STATUS_W-1:0] status;
         logic [RSTATE_W-1:0] range_state;
      } reply_t;

      logic [MARK_WORD_BITS-1:0] marks [MARK_WORDS];
      logic [SHIFT_W-1:0]        shift_reg;
      reply_t                    expected_replies [$];
      int                        failures;

      function new();
         foreach (marks[i]) marks[i] = '0;
         shift_reg = SHIFT_RESET;
         failures  = 0;
      endfunction

      function void set_shift(logic [SHIFT_W-1:0] value);
         shift_reg = value;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      // walk sectors first..first+count-1 a mark word at a time, marking or probing them
      function void sweep_sectors(longint unsigned first, longint unsigned count, bit do_mark,
                                  output bit any_set, output bit any_clear);
         longint unsigned s, stop_at, word_end, w;
         int lo, hi;
         logic [MARK_WORD_BITS:0]   ones;
         logic [MARK_WORD_BITS-1:0] m, v;
         any_set   = 1'b0;
         any_clear = 1'b0;
         s         = first;
         while (s < first + count && !(any_set && any_clear)) begin
            w        = s / MARK_WORD_BITS;
            lo       = int'(s % MARK_WORD_BITS);
            word_end = (w + 1) * MARK_WORD_BITS;
            stop_at  = (first + count < word_end) ? first + count : word_end;
            hi       = int'((stop_at - 1) % MARK_WORD_BITS);
            ones     = ((MARK_WORD_BITS+1)'(1) << (hi - lo + 1)) - 1'b1;
            m        = ones[MARK_WORD_BITS-1:0] << lo;
            if (do_mark) begin
               marks[w] |= m;
            end else begin
               v = marks[w] & m;
               if (v != '0) any_set = 1'b1;
               if (v != m) any_clear = 1'b1;
            end
            s = stop_at;
         end
      endfunction

      // accepted transaction: apply it to the map and queue the reply it must give
      function void note_request(logic cmd, logic [OFFSET_W-1:0] off,
                                 logic [LENGTH_W-1:0] len);
         int unsigned     sh;
         longint unsigned off64, len64, sector_bytes, map_bytes, end_byte, n;
         bit              hit_set, hit_clear;
         reply_t          r;
         sh           = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
         off64        = off;
         len64        = len;
         sector_bytes = 64'd1 << sh;
         map_bytes    = 64'(SECTOR_COUNT) << sh;
         end_byte     = off64 + len64;
         r.status      = STATUS_OK;
         r.range_state = RSTATE_UNKNOWN;
         if (cmd == CMD_SET) begin
            if (((off64 | len64) & (sector_bytes - 1)) != 0) begin
               r.status = STATUS_MISALIGN;
            end else if (end_byte > map_bytes) begin
               r.status = STATUS_BEYOND;
            end else if (len64 != 0) begin
               sweep_sectors(off64 >> sh, len64 >> sh, 1'b1, hit_set, hit_clear);
            end
         end else begin
            if (end_byte > map_bytes) begin
               r.status = STATUS_BEYOND;
            end else if (len64 != 0) begin
               // no alignment check: the length rounded up to whole sectors from the offset's sector
               n = (len64 + sector_bytes - 1) >> sh;
               sweep_sectors(off64 >> sh, n, 1'b0, hit_set, hit_clear);
               if (hit_set && hit_clear) r.range_state = RSTATE_BLENDED;
               else if (hit_set) r.range_state = RSTATE_ALL_SET;
               else r.range_state = RSTATE_ALL_CLR;
            end
         end
         expected_replies.push_back(r);
      endfunction

      // reply seen on the result ports: compare with the oldest prediction
      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [RSTATE_W-1:0] range_state);
         reply_t want;
         if (expected_replies.size() == 0) begin
            $error("reply with none expected: status %0d range_state %0d", status, range_state);
            failures++;
            return;
         end
         want = expected_replies.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (range_state !== want.range_state) begin
            $error("range_state: expected %0d, actual %0d", want.range_state, range_state);
            failures++;
         end
      endfunction
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic                  req_command      = CMD_SET;
   logic [OFFSET_W-1:0]   req_offset_bytes = '0;
   logic [LENGTH_W-1:0]   req_length_bytes = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [RSTATE_W-1:0]   rsp_range_state;
   logic                  csr_wr_en        = 1'b0;
   logic [SHIFT_W-1:0]    csr_wr_data      = '0;

   mark_map_board board;
   int            cycles      = 0;
   int            burst_left  = 1;
   int            huge_left   = 3;

   sector_dirty_bitmap DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_offset_bytes(req_offset_bytes),
      .req_length_bytes(req_length_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_range_state (rsp_range_state),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // sample pre-edge values: replies first, then register writes, then new transactions
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) board.check_response(rsp_status, rsp_range_state);
         if (csr_wr_en) board.set_shift(csr_wr_data);
         if (start && busy === 1'b0)
            board.note_request(req_command, req_offset_bytes, req_length_bytes);
      end
   end

   // present one transaction, hold it until taken, then maybe end the burst
   task automatic issue(logic cmd, logic [OFFSET_W-1:0] off, logic [LENGTH_W-1:0] len,
                        bit last);
      start            <= 1'b1;
      req_command      <= cmd;
      req_offset_bytes <= off;
      req_length_bytes <= len;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0 || last) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic wait_idle();
      while (board.pending() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_shift(logic [SHIFT_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // random transaction: mostly in-map ranges around a hot window, some noise and broken ones
   function automatic void draw_request(int unsigned sh, int unsigned hot_base,
                                        output logic cmd, output logic [OFFSET_W-1:0] off,
                                        output logic [LENGTH_W-1:0] len);
      int unsigned     kind, pick, first, count, sector_bytes;
      longint unsigned map_bytes;
      sector_bytes = 32'd1 << sh;
      map_bytes    = 64'(SECTOR_COUNT) << sh;
      kind         = $urandom_range(0, 99);
      if (kind < 8) begin
         // noise: random fields, offset pushed to or beyond every map size
         cmd = 1'($urandom);
         off = {8'($urandom), $urandom};
         off[OFFSET_W-1:32] |= 8'h01 << $urandom_range(0, 7);
         len = $urandom;
         return;
      end
      if (kind < 10 && huge_left > 0) begin
         // whole-map probe, kept rare as it can walk every mark word
         huge_left--;
         cmd = CMD_TEST;
         off = '0;
         len = (map_bytes > 64'hFFFF_FFFF) ? '1 : LENGTH_W'(map_bytes);
         return;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) first = hot_base + $urandom_range(0, 2047);
      else if (pick < 9) first = SECTOR_COUNT - $urandom_range(1, 700);
      else first = $urandom_range(0, SECTOR_COUNT - 1);
      pick = $urandom_range(0, 19);
      if (pick == 0) count = 0;
      else if (pick < 17) count = $urandom_range(1, 130);
      else count = $urandom_range(131, 1024);
      // most ranges that pass the map end are clipped to it, the rest run off its end
      if (first + count > SECTOR_COUNT && $urandom_range(0, 3) != 0)
         count = SECTOR_COUNT - first;
      cmd = 1'($urandom);
      off = OFFSET_W'(64'(first) << sh);
      len = LENGTH_W'(count << sh);
      if (sh != 0) begin
         if (cmd == CMD_SET) begin
            if ($urandom_range(0, 9) == 0) begin
               if ($urandom_range(0, 1) == 1) off += OFFSET_W'($urandom_range(1, sector_bytes - 1));
               else len += LENGTH_W'($urandom_range(1, sector_bytes - 1));
            end
         end else begin
            off += OFFSET_W'($urandom_range(0, sector_bytes - 1));
            if (len != 0 && $urandom_range(0, 1) == 1)
               len -= LENGTH_W'($urandom_range(0, sector_bytes - 1));
         end
      end
   endfunction

   task automatic run_phase(int unsigned sh, int n);
      int unsigned         hot_base;
      logic                cmd;
      logic [OFFSET_W-1:0] off;
      logic [LENGTH_W-1:0] len;
      hot_base = $urandom_range(0, SECTOR_COUNT - 2049);
      for (int i = 0; i < n; i++) begin
         draw_request(sh, hot_base, cmd, off, len);
         issue(cmd, off, len, i == n - 1);
      end
   endtask

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // let the clearing pass begin before looking for idle
      repeat (3) @(posedge clock);
      wait_idle();

      // directed transactions at the reset sector size of 512 bytes
      issue(CMD_TEST, '0, '0, 1'b0);
      issue(CMD_TEST, '0, 32'h2000_0000, 1'b0);
      issue(CMD_SET, '0, 32'd512, 1'b0);
      issue(CMD_TEST, '0, 32'd1, 1'b0);
      issue(CMD_TEST, '0, 32'd1024, 1'b0);
      issue(CMD_TEST, 40'd512, 32'd512, 1'b0);
      issue(CMD_SET, 40'd1, 32'd512, 1'b0);
      issue(CMD_SET, 40'd1024, 32'd100, 1'b0);
      issue(CMD_SET, MAP_BYTES_9 - 40'd512, 32'd1024, 1'b0);
      issue(CMD_SET, 40'd1024, '0, 1'b0);
      issue(CMD_SET, MAP_BYTES_9 - 40'd512, 32'd512, 1'b0);
      issue(CMD_TEST, MAP_BYTES_9 - 40'd1, 32'd1, 1'b0);
      issue(CMD_TEST, MAP_BYTES_9, 32'd1, 1'b0);
      issue(CMD_TEST, '1, '1, 1'b0);
      issue(CMD_SET, 40'hFF_FFFF_FE00, '0, 1'b0);
      // ranges across a mark word boundary and a whole word
      issue(CMD_SET, 40'd30720, 32'd5120, 1'b0);
      issue(CMD_TEST, 40'd29696, 32'd7168, 1'b0);
      issue(CMD_TEST, 40'd31231, 32'd2, 1'b0);
      issue(CMD_TEST, 40'd35628, 32'd513, 1'b0);
      issue(CMD_SET, 40'd65536, 32'd32768, 1'b0);
      issue(CMD_TEST, 40'd65536, 32'd32768, 1'b0);
      issue(CMD_TEST, '0, '1, 1'b0);
      run_phase(9, 66);

      // largest sector size: full-length probe covers the whole map
      write_shift(4'd12);
      issue(CMD_TEST, '0, '1, 1'b0);
      run_phase(12, 65);

      // shifts above twelve act as twelve, with a random middle shift in between
      write_shift(4'd15);
      run_phase(12, 66);
      begin
         logic [SHIFT_W-1:0] mid_shift;
         mid_shift = SHIFT_W'($urandom_range(1, 11));
         write_shift(mid_shift);
         run_phase(mid_shift, 66);
      end
      write_shift(4'd13);
      run_phase(12, 66);

      // one-byte sectors, closing with the whole map marked
      write_shift(4'd0);
      run_phase(0, 66);
      issue(CMD_SET, '0, 32'h0010_0000, 1'b0);
      issue(CMD_TEST, '0, 32'h0010_0000, 1'b0);
      issue(CMD_TEST, 40'd5, '1, 1'b1);

      while (board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
